// ===== src/blake256_pkg.sv =====
// Shared types, constants and index tables for the BLAKE-256/224 hash core.
// No dependencies.
package blake256_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        last_word;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_end;
	} out_item_t;

	localparam int unsigned CFG_DATA_W = 5;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_DIGEST = 2'd1;

	localparam logic [4:0] DEFAULT_ROUNDS = 5'd14;

	localparam logic [31:0] IV_WIDE [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] IV_NARROW [8] = '{
		32'hC1059ED8, 32'h367CD507, 32'h3070DD17, 32'hF70E5939,
		32'hFFC00B31, 32'h68581511, 32'h64F98FA7, 32'hBEFA4FA4
	};

	localparam logic [31:0] PI_CONST [16] = '{
		32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
		32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
		32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
		32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917
	};

	localparam logic [3:0] PERM [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
	};

	// State word indexes a, b, c, d of each lane: columns, then diagonals
	localparam logic [3:0] LANE_IDX [2][4][4] = '{
		'{'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd1, 4'd5, 4'd9, 4'd13},
		  '{4'd2, 4'd6, 4'd10, 4'd14}, '{4'd3, 4'd7, 4'd11, 4'd15}},
		'{'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd1, 4'd6, 4'd11, 4'd12},
		  '{4'd2, 4'd7, 4'd8, 4'd13}, '{4'd3, 4'd4, 4'd9, 4'd14}}
	};

	typedef logic [3:0][31:0] lane_vec_t;

endpackage

// ===== src/blake256_hash_core.sv =====
// BLAKE-256/224 hash core: word buffer, padding, round sequencer, digest output.
// Depends on blake256_pkg and blake256_mix.
// A message word is taken while the core is idle; a full block then runs R rounds,
// half a round per cycle through the shared mix unit, and a finish step.
// A last word adds a pad step and the final block (plus an extra block when
// the padding spills into one), then 7 or 8 digest output words.
// No new word is taken while the core is busy with a block, padding or digest output.
// Reset: asynchronous, active low; registers return to 14 rounds, 256-bit IV.
module blake256_hash_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  blake256_pkg::in_item_t                  in_data,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output blake256_pkg::out_item_t                 out_data,
	input  logic                                    cfg_we,
	input  logic [blake256_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [blake256_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import blake256_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ROUND = 6'b000010,
		ST_FIN   = 6'b000100,
		ST_PAD   = 6'b001000,
		ST_SPILL = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		AFT_IDLE  = 2'd0,
		AFT_PAD   = 2'd1,
		AFT_SPILL = 2'd2,
		AFT_OUT   = 2'd3
	} after_t;

	typedef logic [31:0] work_vec_t [16];
	typedef logic [31:0] chain_vec_t [8];

	state_t       state_q;
	after_t       after_q;
	logic [4:0]   round_count_q;
	logic         wide_q;
	logic [31:0]  cv_q [8];
	logic [31:0]  blk_q [16];
	logic [31:0]  v_q [16];
	logic [3:0]   filled_q;
	logic [63:0]  ctr_q;
	logic [4:0]   round_q;
	logic [3:0]   rmod_q;
	logic         half_q;
	logic [1:0]   pad_bytes_q;
	logic [31:0]  pad_word_q;
	logic [2:0]   out_idx_q;
	logic         out_valid_q;
	out_item_t    out_data_q;

	logic [4:0]   rounds_eff;
	lane_vec_t    ga, gb, gc, gd, gm0, gm1, ra, rb, rc, rd;
	logic [31:0]  v_next [16];
	logic         in_acc;
	logic [2:0]   vb_clamp;
	logic         full_word;
	logic [31:0]  marker;
	logic [8:0]   msgbits;
	logic [63:0]  pad_ctr;
	logic [31:0]  pad_blk [16];
	logic [2:0]   last_idx;
	logic         out_load;

	assign rounds_eff = (round_count_q == '0) ? DEFAULT_ROUNDS : round_count_q;
	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign vb_clamp   = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
	assign full_word  = !in_data.last_word || (vb_clamp == 3'd4);
	assign last_idx   = wide_q ? 3'd7 : 3'd6;
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	// Gather lane operands and message words for this half round
	always_comb begin
		logic [3:0] pe0, pe1;
		for (int j = 0; j < 4; j++) begin
			ga[j] = v_q[LANE_IDX[half_q][j][0]];
			gb[j] = v_q[LANE_IDX[half_q][j][1]];
			gc[j] = v_q[LANE_IDX[half_q][j][2]];
			gd[j] = v_q[LANE_IDX[half_q][j][3]];
			pe0 = PERM[rmod_q][4'(8 * int'(half_q) + 2 * j)];
			pe1 = PERM[rmod_q][4'(8 * int'(half_q) + 2 * j + 1)];
			gm0[j] = blk_q[pe0] ^ PI_CONST[pe1];
			gm1[j] = blk_q[pe1] ^ PI_CONST[pe0];
		end
	end

	blake256_mix u_mix (
		.a(ga), .b(gb), .c(gc), .d(gd), .m0(gm0), .m1(gm1),
		.a_o(ra), .b_o(rb), .c_o(rc), .d_o(rd)
	);

	always_comb begin
		v_next = v_q;
		for (int j = 0; j < 4; j++) begin
			v_next[LANE_IDX[half_q][j][0]] = ra[j];
			v_next[LANE_IDX[half_q][j][1]] = rb[j];
			v_next[LANE_IDX[half_q][j][2]] = rc[j];
			v_next[LANE_IDX[half_q][j][3]] = rd[j];
		end
	end

	// Padded block contents for the final word
	always_comb begin
		unique case (pad_bytes_q)
			2'd0: marker = 32'h8000_0000;
			2'd1: marker = {pad_word_q[31:24], 24'h80_0000};
			2'd2: marker = {pad_word_q[31:16], 16'h8000};
			2'd3: marker = {pad_word_q[31:8], 8'h80};
			default: marker = 32'h8000_0000;
		endcase
		msgbits = {filled_q, 5'd0} + {4'd0, pad_bytes_q, 3'd0};
		pad_ctr = ctr_q + 64'(msgbits);
		for (int i = 0; i < 16; i++) begin
			if (4'(i) == filled_q)
				pad_blk[i] = marker;
			else if (4'(i) > filled_q)
				pad_blk[i] = '0;
			else
				pad_blk[i] = blk_q[i];
		end
		if (filled_q < 4'd14) begin
			pad_blk[13] = pad_blk[13] ^ {31'd0, wide_q};
			pad_blk[14] = pad_ctr[63:32];
			pad_blk[15] = pad_ctr[31:0];
		end
	end

	function automatic work_vec_t init_v(input chain_vec_t cv, input logic [63:0] ctr);
		work_vec_t v;
		for (int i = 0; i < 8; i++) begin
			v[i]     = cv[i];
			v[i + 8] = PI_CONST[i];
		end
		v[12] = v[12] ^ ctr[31:0];
		v[13] = v[13] ^ ctr[31:0];
		v[14] = v[14] ^ ctr[63:32];
		v[15] = v[15] ^ ctr[63:32];
		return v;
	endfunction

	// Payload registers: block buffer and working state
	always_ff @(posedge clk) begin
		if (in_acc && full_word) begin
			blk_q[filled_q] <= in_data.message_word;
		end
		if (state_q == ST_PAD) begin
			blk_q <= pad_blk;
		end
		if (state_q == ST_SPILL) begin
			for (int i = 0; i < 13; i++) blk_q[i] <= '0;
			blk_q[13] <= {31'd0, wide_q};
			blk_q[14] <= ctr_q[63:32];
			blk_q[15] <= ctr_q[31:0];
		end
		if (in_acc) begin
			pad_word_q <= in_data.message_word;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && full_word && filled_q == 4'd15)
					v_q <= init_v(cv_q, ctr_q + 64'd512);
			end
			ST_ROUND: v_q <= v_next;
			ST_PAD: begin
				if (filled_q >= 4'd14)
					v_q <= init_v(cv_q, pad_ctr);
				else if (msgbits != '0)
					v_q <= init_v(cv_q, pad_ctr);
				else
					v_q <= init_v(cv_q, 64'd0);
			end
			ST_SPILL: v_q <= init_v(cv_q, 64'd0);
			default: ;
		endcase
		if (out_load) begin
			out_data_q.digest_word <= cv_q[out_idx_q];
			out_data_q.digest_end  <= (out_idx_q == last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			after_q       <= AFT_IDLE;
			round_count_q <= DEFAULT_ROUNDS;
			wide_q        <= 1'b1;
			cv_q          <= IV_WIDE;
			filled_q      <= '0;
			ctr_q         <= '0;
			round_q       <= '0;
			rmod_q        <= '0;
			half_q        <= 1'b0;
			pad_bytes_q   <= '0;
			out_idx_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// A write to either mapped register restarts the message
			if (cfg_we && (cfg_index == REG_ROUND_COUNT || cfg_index == REG_WIDE_DIGEST)) begin
				if (cfg_index == REG_ROUND_COUNT) begin
					round_count_q <= cfg_data;
					cv_q <= wide_q ? IV_WIDE : IV_NARROW;
				end else begin
					wide_q <= cfg_data[0];
					cv_q <= cfg_data[0] ? IV_WIDE : IV_NARROW;
				end
				filled_q <= '0;
				ctr_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pad_bytes_q <= full_word ? 2'd0 : vb_clamp[1:0];
						if (full_word) begin
							filled_q <= filled_q + 4'd1;
							if (filled_q == 4'd15) begin
								ctr_q   <= ctr_q + 64'd512;
								after_q <= in_data.last_word ? AFT_PAD : AFT_IDLE;
								round_q <= '0;
								rmod_q  <= '0;
								half_q  <= 1'b0;
								state_q <= ST_ROUND;
							end else if (in_data.last_word) begin
								state_q <= ST_PAD;
							end
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					half_q <= !half_q;
					if (half_q) begin
						round_q <= round_q + 5'd1;
						rmod_q  <= (rmod_q == 4'd9) ? 4'd0 : rmod_q + 4'd1;
						if (round_q == rounds_eff - 5'd1)
							state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					for (int i = 0; i < 8; i++)
						cv_q[i] <= cv_q[i] ^ v_q[i] ^ v_q[i + 8];
					unique case (after_q)
						AFT_IDLE:  state_q <= ST_IDLE;
						AFT_PAD:   state_q <= ST_PAD;
						AFT_SPILL: state_q <= ST_SPILL;
						AFT_OUT: begin
							out_idx_q <= '0;
							state_q   <= ST_OUT;
						end
						default:   state_q <= ST_IDLE;
					endcase
				end
				ST_PAD: begin
					ctr_q   <= pad_ctr;
					after_q <= (filled_q >= 4'd14) ? AFT_SPILL : AFT_OUT;
					round_q <= '0;
					rmod_q  <= '0;
					half_q  <= 1'b0;
					state_q <= ST_ROUND;
				end
				ST_SPILL: begin
					after_q <= AFT_OUT;
					round_q <= '0;
					rmod_q  <= '0;
					half_q  <= 1'b0;
					state_q <= ST_ROUND;
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= out_idx_q + 3'd1;
						if (out_idx_q == last_idx) begin
							cv_q     <= wide_q ? IV_WIDE : IV_NARROW;
							filled_q <= '0;
							ctr_q    <= '0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state register not one-hot");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && half_q && round_q == rounds_eff - 5'd1) |=> state_q == ST_FIN)
		else $error("round sequencer overran the round count");

	a_digest_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_idx_q == last_idx) |=> (out_data_q.digest_end && state_q == ST_IDLE))
		else $error("last digest word not flagged");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND || state_q == ST_OUT) |-> !in_acc)
		else $error("transaction accepted while compressing or emitting");

endmodule

// ===== src/blake256_mix.sv =====
// Four parallel BLAKE G functions: one half round of the compression.
// Depends on blake256_pkg.
module blake256_mix (
	input  blake256_pkg::lane_vec_t a,
	input  blake256_pkg::lane_vec_t b,
	input  blake256_pkg::lane_vec_t c,
	input  blake256_pkg::lane_vec_t d,
	input  blake256_pkg::lane_vec_t m0,
	input  blake256_pkg::lane_vec_t m1,
	output blake256_pkg::lane_vec_t a_o,
	output blake256_pkg::lane_vec_t b_o,
	output blake256_pkg::lane_vec_t c_o,
	output blake256_pkg::lane_vec_t d_o
);
	import blake256_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
		for (int j = 0; j < 4; j++) begin
			a1 = a[j] + b[j] + m0[j];
			d1 = rotr(d[j] ^ a1, 16);
			c1 = c[j] + d1;
			b1 = rotr(b[j] ^ c1, 12);
			a2 = a1 + b1 + m1[j];
			d2 = rotr(d1 ^ a2, 8);
			c2 = c1 + d2;
			b2 = rotr(b1 ^ c2, 7);
			a_o[j] = a2;
			b_o[j] = b2;
			c_o[j] = c2;
			d_o[j] = d2;
		end
	end

endmodule

// ===== test/tb_blake256_hash_core.sv =====
// Self-checking testbench for blake256_hash_core: streams messages, predicts
// digests with an in-bench BLAKE-256/224 model and compares every digest word.
// Depends on blake256_pkg and the hash core RTL.
`timescale 1ns / 100ps

module tb_blake256_hash_core;
	import blake256_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	blake256_hash_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// predictor state
	logic [4:0]  hash_rounds = DEFAULT_ROUNDS;
	logic        hash_wide = 1'b1;
	logic [31:0] chain [8];
	logic [31:0] msg_block [16];
	int unsigned fill_count = 0;
	logic [63:0] msg_bits = '0;

	out_item_t digest_queue [$];
	int unsigned error_count = 0;
	int unsigned word_count = 0;
	int unsigned digest_count = 0;
	int unsigned message_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_cycles = 0;
	longint unsigned cycle_count = 0;

	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block(logic [63:0] ctr);
		logic [31:0] v [16];
		int nr;
		int a, b, c, d, x, y;
		nr = (hash_rounds == 0) ? 14 : hash_rounds;
		for (int i = 0; i < 8; i++) begin
			v[i] = chain[i];
			v[i + 8] = PI_CONST[i];
		end
		v[12] ^= ctr[31:0];
		v[13] ^= ctr[31:0];
		v[14] ^= ctr[63:32];
		v[15] ^= ctr[63:32];
		for (int r = 0; r < nr; r++) begin
			for (int g = 0; g < 8; g++) begin
				a = LANE_IDX[g / 4][g % 4][0];
				b = LANE_IDX[g / 4][g % 4][1];
				c = LANE_IDX[g / 4][g % 4][2];
				d = LANE_IDX[g / 4][g % 4][3];
				x = PERM[r % 10][2 * g];
				y = PERM[r % 10][2 * g + 1];
				v[a] = v[a] + v[b] + (msg_block[x] ^ PI_CONST[y]);
				v[d] = rotr(v[d] ^ v[a], 16);
				v[c] = v[c] + v[d];
				v[b] = rotr(v[b] ^ v[c], 12);
				v[a] = v[a] + v[b] + (msg_block[y] ^ PI_CONST[x]);
				v[d] = rotr(v[d] ^ v[a], 8);
				v[c] = v[c] + v[d];
				v[b] = rotr(v[b] ^ v[c], 7);
			end
		end
		for (int i = 0; i < 8; i++)
			chain[i] ^= v[i] ^ v[i + 8];
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			chain[i] = hash_wide ? IV_WIDE[i] : IV_NARROW[i];
		fill_count = 0;
		msg_bits = '0;
	endtask

	task automatic predict_digest(in_item_t it);
		int unsigned nb, m, nw;
		logic [31:0] w;
		logic [63:0] final_ctr;
		logic [31:0] bits;
		nb = (it.valid_bytes > 4) ? 4 : it.valid_bytes;
		w = it.message_word;
		if (!it.last_word || nb == 4) begin
			msg_block[fill_count] = w;
			fill_count = (fill_count + 1) % 16;
			if (fill_count == 0) begin
				msg_bits += 512;
				compress_block(msg_bits);
			end
			if (!it.last_word)
				return;
			nb = 0;
		end
		m = fill_count;
		if (nb == 0)
			w = 32'h8000_0000;
		else
			w = (w & (32'hFFFF_FFFF << (32 - 8 * nb))) | (32'h80 << (24 - 8 * nb));
		msg_block[m] = w;
		bits = 32 * m + 8 * nb;
		msg_bits += bits;
		final_ctr = (bits != 0) ? msg_bits : '0;
		if (m >= 14) begin
			for (int i = m + 1; i < 16; i++)
				msg_block[i] = '0;
			compress_block(msg_bits);
			for (int i = 0; i < 14; i++)
				msg_block[i] = '0;
			final_ctr = '0;
		end else begin
			for (int i = m + 1; i < 14; i++)
				msg_block[i] = '0;
		end
		if (hash_wide)
			msg_block[13] ^= 32'h1;
		msg_block[14] = msg_bits[63:32];
		msg_block[15] = msg_bits[31:0];
		compress_block(final_ctr);
		nw = hash_wide ? 8 : 7;
		for (int i = 0; i < nw; i++)
			digest_queue.push_back('{digest_word: chain[i], digest_end: (i == nw - 1)});
		message_count++;
		restart_message();
	endtask

	// accept one word and feed it to the predictor, which records the digest words of a last word
	task automatic send_word(logic [31:0] w, logic [2:0] nb, logic last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{message_word: w, valid_bytes: nb, last_word: last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_digest('{message_word: w, valid_bytes: nb, last_word: last});
		word_count++;
		@(negedge clk);
	endtask

	task automatic send_message(int unsigned len, logic [2:0] last_nb);
		for (int i = 0; i < len; i++)
			send_word($urandom, (i == len - 1) ? last_nb : 3'($urandom_range(7)), i == len - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (digest_queue.size() != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [4:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROUND_COUNT)
			hash_rounds = val;
		else if (idx == REG_WIDE_DIGEST)
			hash_wide = val[0];
		if (idx == REG_ROUND_COUNT || idx == REG_WIDE_DIGEST)
			restart_message();
	endtask

	// receiver: random stall, long hold-offs on request
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t exp_item;
		cycle_count++;
		if (out_valid && !out_stall && arst_n) begin
			if (digest_queue.size() == 0) begin
				$display("%0t: unexpected digest word %h end %b", $time,
					out_data.digest_word, out_data.digest_end);
				error_count++;
			end else begin
				exp_item = digest_queue.pop_front();
				digest_count++;
				if (out_data.digest_word !== exp_item.digest_word ||
				    out_data.digest_end !== exp_item.digest_end) begin
					$display("%0t: mismatch expected %h/%b actual %h/%b", $time,
						exp_item.digest_word, exp_item.digest_end,
						out_data.digest_word, out_data.digest_end);
					error_count++;
				end
			end
		end
		if (cycle_count > 400000) begin
			$display("timeout with %0d digest words pending", digest_queue.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_directed();
		send_word(32'h0, 3'd0, 1'b1);          // empty message
		send_word(32'hFFFF_FFFF, 3'd1, 1'b1);  // trailing bytes overwritten by pad
		send_word(32'h0000_0000, 3'd4, 1'b1);
		send_word(32'hA5A5_5A5A, 3'd7, 1'b1);  // above four counts as four
		send_message(3, 3'd2);
		send_message(14, 3'd3);                // last partial word lands in word 13; pad still fits
		send_message(15, 3'd0);
		send_message(16, 3'd4);                // whole blocks, bit-free final block
		send_message(16, 3'd0);
	endtask

	task automatic test_config();
		write_reg(REG_ROUND_COUNT, 5'd0);
		send_message(5, 3'd3);
		write_reg(REG_WIDE_DIGEST, 5'd0);
		send_message(2, 3'd4);
		send_message(14, 3'd1);
		write_reg(REG_ROUND_COUNT, 5'd1);
		send_message(17, 3'd2);
		write_reg(REG_ROUND_COUNT, 5'd31);
		send_message(4, 3'd0);
		write_reg(2'd3, 5'd9);                 // unmapped index, ignored
		send_message(3, 3'd1);
		write_reg(REG_WIDE_DIGEST, 5'd1);
		write_reg(REG_ROUND_COUNT, 5'd14);
	endtask

	task automatic test_random(int unsigned n_words);
		int unsigned goal;
		goal = word_count + n_words;
		while (word_count < goal) begin
			if ($urandom_range(9) == 0)
				send_message($urandom_range(33, 17), 3'($urandom_range(7)));
			else
				send_message($urandom_range(6, 1), 3'($urandom_range(7)));
		end
	endtask

	task automatic test_pressure();
		wait_drained();
		hold_cycles = 300;
		send_message(16, 3'd4);
		send_message(3, 3'd2);
		send_message(2, 3'd1);
		wait_drained();
	endtask

	initial begin
		restart_message();
		for (int i = 0; i < 16; i++)
			msg_block[i] = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_config();
		send_idle_pct = 18; recv_idle_pct = 57;
		test_random(65);
		write_reg(REG_ROUND_COUNT, 5'd3);
		send_idle_pct = 57; recv_idle_pct = 18;
		test_random(65);
		write_reg(REG_WIDE_DIGEST, 5'd0);
		send_idle_pct = 0; recv_idle_pct = 0;
		test_random(40);
		test_pressure();
		wait_drained();
		$display("covered %0d words, %0d messages, %0d digest words checked",
			word_count, message_count, digest_count);
		$display("round counts 0,1,3,14,31 and both digest widths");
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
